FILE: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared widths, types, codes and helpers for the fingerprint similarity
// screen.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int WORD_BITS        = 64;
  localparam int WORDS_PER_VECTOR = 16;
  localparam int SLOTS            = 16;

  localparam int PORT_WORD_W = 64;
  localparam int ID_W        = 16;
  localparam int COEF_W      = 8;
  localparam int LC_W        = 12;

  localparam int PART_W = (WORDS_PER_VECTOR > 1) ? $clog2(WORDS_PER_VECTOR) : 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WPC_W  = $clog2(WORD_BITS + 1);
  localparam int CNT_W  = $clog2(WORD_BITS * WORDS_PER_VECTOR + 1);
  localparam int RHS_W  = CNT_W + 1;
  localparam int LHS_W  = CNT_W + COEF_W + 1;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [PORT_WORD_W-1:0] port_word_t;
  typedef logic [PART_W-1:0]      part_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [WPC_W-1:0]       wpc_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [RHS_W-1:0]       rhs_t;
  typedef logic [LHS_W-1:0]       lhs_t;
  typedef logic [COEF_W-1:0]      coef_t;
  typedef logic [ID_W-1:0]        id_t;
  typedef logic [LC_W-1:0]        lc_t;
  typedef logic [SLOTS-1:0]       match_t;

  localparam part_t LAST_PART  = part_t'(WORDS_PER_VECTOR - 1);
  localparam slot_t LAST_SLOT  = slot_t'(SLOTS - 1);
  localparam coef_t COEF_RESET = coef_t'(2);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REF  = 1'b1;

  // one beat as it travels down the row of cells
  typedef struct packed {
    logic   valid;
    logic   load;
    logic   last;
    slot_t  slot;
    part_t  part;
    word_t  word;
    wpc_t   wpc;
    cnt_t   qpop;
    id_t    ref_id;
    id_t    base;
    match_t match;
  } beat_t;

  function automatic wpc_t popcount(input word_t v);
    wpc_t n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + wpc_t'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: rtl/tts_in_if.sv
// ----------------------------------------------------------------------------
// tts_in_if
// Input channel: load or reference words with valid/ready.
// ----------------------------------------------------------------------------
interface tts_in_if;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  tts_pkg::port_word_t   word;
  tts_pkg::id_t          ref_index;

  modport source (output valid, output mode, output word, output ref_index, input ready);
  modport sink   (input valid, input mode, input word, input ref_index, output ready);
endinterface

FILE: rtl/tts_out_if.sv
// ----------------------------------------------------------------------------
// tts_out_if
// Output channel: match pairs with valid/ready.
// ----------------------------------------------------------------------------
interface tts_out_if;
  logic         valid;
  logic         ready;
  tts_pkg::id_t ref_id;
  tts_pkg::id_t cmp_id;
  logic         last;

  modport source (output valid, output ref_id, output cmp_id, output last, input ready);
  modport sink   (input valid, input ref_id, input cmp_id, input last, output ready);
endinterface

FILE: rtl/tanimoto_threshold_screen.sv
// ----------------------------------------------------------------------------
// tanimoto_threshold_screen
// Bit-fingerprint similarity screen: a row of compare cells, one per stored
// fingerprint, counts common bits with each streamed query and reports the
// slots whose (coef + 1)-weighted common count reaches the sum of popcounts.
//
//   port       dir   beat contents
//   din        in    mode, word, ref_index
//   dout       out   ref_id, cmp_id, last
//   cfg_we     in    coefficient write strobe with cfg_data
//
// One word is taken per cycle while din.ready is high; a word crosses the
// input stage and five stages in each of the SLOTS cells before its query's
// pairs start. Pairs leave one per cycle while dout.ready is high, limited by
// the result stage. din.ready drops while a finished query waits for the
// previous query's pairs. Synchronous reset clears counters, pipeline valids
// and common counts; the stored words need no clearing.
// ----------------------------------------------------------------------------
module tanimoto_threshold_screen (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  tts_pkg::coef_t cfg_data,
  tts_in_if.sink         din,
  tts_out_if.source      dout
);

  tts_pkg::coef_t coef;
  tts_pkg::beat_t link [tts_pkg::SLOTS + 1];
  logic           adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= tts_pkg::COEF_RESET;
    end else if (cfg_we) begin
      coef <= cfg_data;
    end
  end

  tts_feed u_feed (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .din  (din),
    .beat (link[0])
  );

  for (genvar k = 0; k < tts_pkg::SLOTS; k++) begin : g_cell
    tts_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .coef    (coef),
      .slot_id (tts_pkg::slot_t'(k)),
      .bin     (link[k]),
      .bout    (link[k+1])
    );
  end

  tts_emit u_emit (
    .clk  (clk),
    .rst  (rst),
    .tail (link[tts_pkg::SLOTS]),
    .adv  (adv),
    .dout (dout)
  );

endmodule

FILE: rtl/tts_feed.sv
// ----------------------------------------------------------------------------
// tts_feed
// Input stage: tracks load and query positions, query popcount and load count;
// sends the cell row a beat per accepted load word, or query word once loaded.
// ----------------------------------------------------------------------------
module tts_feed (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  tts_in_if.sink         din,
  output tts_pkg::beat_t beat
);

  tts_pkg::slot_t load_slot;
  tts_pkg::part_t load_part;
  tts_pkg::part_t qpart;
  tts_pkg::cnt_t  qpop;
  tts_pkg::lc_t   lc;
  logic           loaded;

  tts_pkg::word_t wrd;
  tts_pkg::wpc_t  pc_in;
  tts_pkg::cnt_t  qpop_next;
  tts_pkg::lc_t   lc_m1;
  logic           acc;

  assign din.ready = adv;
  assign acc       = din.valid && adv;
  assign wrd       = din.word[tts_pkg::WORD_BITS-1:0];
  assign pc_in     = tts_pkg::popcount(wrd);
  assign qpop_next = (qpart == '0) ? tts_pkg::cnt_t'(pc_in)
                                   : qpop + tts_pkg::cnt_t'(pc_in);
  assign lc_m1     = lc - tts_pkg::lc_t'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      beat.load   <= din.mode == tts_pkg::MODE_LOAD;
      beat.last   <= qpart == tts_pkg::LAST_PART;
      beat.slot   <= load_slot;
      beat.part   <= (din.mode == tts_pkg::MODE_LOAD) ? load_part : qpart;
      beat.word   <= wrd;
      beat.wpc    <= pc_in;
      beat.qpop   <= qpop_next;
      beat.ref_id <= din.ref_index + tts_pkg::id_t'(1);
      beat.base   <= tts_pkg::id_t'(32'(lc_m1) * 32'(tts_pkg::SLOTS));
      beat.match  <= '0;
    end
    if (rst) begin
      beat.valid <= 1'b0;
      load_slot  <= '0;
      load_part  <= '0;
      qpart      <= '0;
      qpop       <= '0;
      lc         <= '0;
      loaded     <= 1'b0;
    end else begin
      if (adv) begin
        beat.valid <= acc && (din.mode == tts_pkg::MODE_LOAD || loaded);
      end
      if (acc) begin
        if (din.mode == tts_pkg::MODE_LOAD) begin
          if (load_part == tts_pkg::LAST_PART) begin
            load_part <= '0;
            if (load_slot == tts_pkg::LAST_SLOT) begin
              load_slot <= '0;
              lc        <= lc + tts_pkg::lc_t'(1);
              loaded    <= 1'b1;
            end else begin
              load_slot <= load_slot + tts_pkg::slot_t'(1);
            end
          end else begin
            load_part <= load_part + tts_pkg::part_t'(1);
          end
        end else if (loaded) begin
          qpop  <= qpop_next;
          qpart <= (qpart == tts_pkg::LAST_PART) ? '0 : qpart + tts_pkg::part_t'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/tts_cell.sv
// ----------------------------------------------------------------------------
// tts_cell
// One compare slot: holds its fingerprint words, their popcount and the
// running common count; passes every beat on through five stages.
// ----------------------------------------------------------------------------
module tts_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  tts_pkg::coef_t  coef,
  input  tts_pkg::slot_t  slot_id,
  input  tts_pkg::beat_t  bin,
  output tts_pkg::beat_t  bout
);

  tts_pkg::word_t mem [tts_pkg::WORDS_PER_VECTOR];
  tts_pkg::cnt_t  cmp_pop;
  tts_pkg::cnt_t  common;

  tts_pkg::beat_t s1, s2, s3, s4;
  tts_pkg::word_t q;
  tts_pkg::wpc_t  pc;
  tts_pkg::cnt_t  c_sum;
  tts_pkg::rhs_t  rhs1, rhs2, rhs3, rhs4;
  tts_pkg::lhs_t  prod;

  tts_pkg::cnt_t  c_next;
  tts_pkg::beat_t s4_out;
  logic           hit;

  assign hit    = bin.valid && bin.load && bin.slot == slot_id;
  assign c_next = common + tts_pkg::cnt_t'(pc);

  always_comb begin
    s4_out = s4;
    if (s4.valid && !s4.load && s4.last && prod >= tts_pkg::lhs_t'(rhs4)) begin
      s4_out.match = s4.match | (tts_pkg::match_t'(1) << slot_id);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= mem[bin.part];
      if (hit) begin
        mem[bin.part] <= bin.word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid   <= 1'b0;
      s2.valid   <= 1'b0;
      s3.valid   <= 1'b0;
      s4.valid   <= 1'b0;
      bout.valid <= 1'b0;
      common     <= '0;
    end else if (en) begin
      if (hit) begin
        cmp_pop <= (bin.part == '0) ? tts_pkg::cnt_t'(bin.wpc)
                                    : cmp_pop + tts_pkg::cnt_t'(bin.wpc);
      end
      s1 <= bin;
      // stored popcount taken as it stands when the word enters the cell
      rhs1 <= tts_pkg::rhs_t'(bin.qpop) + tts_pkg::rhs_t'(cmp_pop);
      s2   <= s1;
      rhs2 <= rhs1;
      pc   <= tts_pkg::popcount(s1.word & q);
      s3    <= s2;
      c_sum <= c_next;
      rhs3  <= rhs2;
      s4   <= s3;
      prod <= (tts_pkg::lhs_t'(coef) + tts_pkg::lhs_t'(1)) * tts_pkg::lhs_t'(c_sum);
      rhs4 <= rhs3;
      bout <= s4_out;
      if (s2.valid && !s2.load) begin
        // common count restarts after the last word of a fingerprint
        common <= s2.last ? '0 : c_next;
      end
    end
  end

endmodule

FILE: rtl/tts_emit.sv
// ----------------------------------------------------------------------------
// tts_emit
// Result stage: takes the match vector of a finished fingerprint from the
// end of the cell row and sends one pair per set bit, lowest slot first.
// ----------------------------------------------------------------------------
module tts_emit (
  input  logic           clk,
  input  logic           rst,
  input  tts_pkg::beat_t tail,
  output logic           adv,
  tts_out_if.source      dout
);

  tts_pkg::match_t pend;
  tts_pkg::id_t    ref_id;
  tts_pkg::id_t    base;

  tts_pkg::match_t low;
  tts_pkg::match_t rest;
  tts_pkg::slot_t  idx;
  logic            take;

  // hold the row while a finished fingerprint waits for the previous one
  assign adv  = !(tail.valid && !tail.load && tail.last && pend != '0);
  assign low  = pend & (~pend + tts_pkg::match_t'(1));
  assign rest = pend & ~low;
  assign take = pend != '0 && (!dout.valid || dout.ready);

  always_comb begin
    idx = '0;
    for (int i = 0; i < tts_pkg::SLOTS; i++) begin
      if (low[i]) begin
        idx = tts_pkg::slot_t'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dout.ref_id <= ref_id;
      dout.cmp_id <= base + tts_pkg::id_t'(idx) + tts_pkg::id_t'(1);
      dout.last   <= rest == '0;
    end
    if (pend == '0 && tail.valid && !tail.load && tail.last) begin
      ref_id <= tail.ref_id;
      base   <= tail.base;
    end
    if (rst) begin
      pend       <= '0;
      dout.valid <= 1'b0;
    end else begin
      if (take) begin
        pend       <= rest;
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
      if (pend == '0 && tail.valid && !tail.load && tail.last) begin
        pend <= tail.match;
      end
    end
  end

endmodule

FILE: rtl/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks on the result channel of the screen.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic         clk,
  input logic         rst,
  input logic         out_valid,
  input logic         out_ready,
  input tts_pkg::id_t out_ref_id,
  input tts_pkg::id_t out_cmp_id,
  input logic         out_last
);

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ref_id)
      && $stable(out_cmp_id) && $stable(out_last))
    else $error("stalled result changed");

  // pairs of one query go out back to back under the same reference id
  a_group_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid && out_ref_id == $past(out_ref_id))
    else $error("query results not contiguous");

endmodule

bind tanimoto_threshold_screen tts_checker u_tts_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .out_ref_id (dout.ref_id),
  .out_cmp_id (dout.cmp_id),
  .out_last   (dout.last)
);
